[hdl/ttdpd_pkg.sv]
// Package for the tick timebase and DC pulse detector.
// Holds the register map, reset values, widths and the result word layout.
// No dependencies.
package ttdpd_pkg;

  localparam int GapCounterBits = 16;
  localparam int CfgAddrBits    = 5;
  localparam int CfgDataBits    = 32;

  typedef logic [GapCounterBits-1:0] gap_t;

  typedef enum logic [2:0] {
    REG_PRESCALE    = 3'd0,
    REG_TPS         = 3'd1,
    REG_TPH         = 3'd2,
    REG_GAP_MIN     = 3'd3,
    REG_GAP_MAX     = 3'd4,
    REG_PULSES      = 3'd5,
    REG_DC_CLEAR    = 3'd6,
    REG_PREHEAT     = 3'd7
  } reg_idx_t;

  localparam logic [7:0]  RstPrescale = 8'd40;
  localparam logic [7:0]  RstTps      = 8'd250;
  localparam logic [7:0]  RstTph      = 8'd125;
  localparam logic [15:0] RstGapMin   = 16'd170;
  localparam logic [15:0] RstGapMax   = 16'd350;
  localparam logic [7:0]  RstPulses   = 8'd2;
  localparam logic [2:0]  RstDcClear  = 3'd5;
  localparam logic [7:0]  RstPreheat  = 8'd10;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_EDGE = 1'b1;

  // result word, last field in the lowest bit
  typedef struct packed {
    logic dc_present;
    logic preheat_done;
    logic sleep_clear;
    logic sleep_tick;
    logic second_tick;
    logic half_second_tick;
    logic key_tick;
    logic four_ms_tick;
  } result_t;

endpackage

[hdl/tick_timebase_dc_pulse_detector.sv]
// Top level of the tick timebase and DC pulse detector.
// Depends on ttdpd_pkg for the register map and result word layout.
//
//  channel | direction | word
//  in_     | slave     | tuser: action; tdata: standby_ok, zero filled to 8 bits
//  out_    | master    | tdata: eight result flags, four_ms_tick in bit 0
//  cfg_    | APB slave | eight registers at byte addresses 4*i
//
// One word is accepted per cycle; its result appears in the output register the
// next cycle, set by the single counter-update stage feeding that register.
// Reset (synchronous, rst_n low) zeroes all counters and the DC flag and loads
// register defaults. A stalled output holds its word; the input stalls only
// while the output register is full and not being taken.
module tick_timebase_dc_pulse_detector (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,    // [0] standby_ok
  input  logic [0:0]                           in_tuser,    // [0] action
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] four_ms_tick [1] key_tick [2] half_second_tick [3] second_tick
  // [4] sleep_tick [5] sleep_clear [6] preheat_done [7] dc_present
  output logic [7:0]                           out_tdata,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [ttdpd_pkg::CfgAddrBits-1:0]    cfg_paddr,
  input  logic [ttdpd_pkg::CfgDataBits-1:0]    cfg_pwdata,
  output logic [ttdpd_pkg::CfgDataBits-1:0]    cfg_prdata,
  output logic                                 cfg_pready
);

  localparam ttdpd_pkg::gap_t GapMax = '1;

  logic [7:0]       prescale_r, tps_r, tph_r, pulses_r, preheat_r;
  logic [15:0]      gap_min_r, gap_max_r;
  logic [2:0]       dc_clear_r;

  logic [7:0]       sub_r, sub_nxt;
  logic [7:0]       ms_r, ms_nxt;
  logic [7:0]       half_r, half_nxt;
  logic [2:0]       clr_r, clr_nxt;
  logic [7:0]       elapsed_r, elapsed_nxt;
  ttdpd_pkg::gap_t  gap_r, gap_nxt;
  logic [7:0]       vpc_r, vpc_nxt;
  logic             dc_r, dc_nxt;

  ttdpd_pkg::result_t res_nxt, res_r;
  logic             out_valid_r;

  logic             in_acc, cfg_wr;
  ttdpd_pkg::reg_idx_t cfg_idx;

  logic [7:0]       sub_inc, ms_inc, half_inc, el_inc, vpc_inc;
  logic [2:0]       clr_inc;
  ttdpd_pkg::gap_t  gap_inc;
  logic             fire4, fire_sec, fire_half, fire_clr, gap_ok;
  logic [16:0]      gap_ext;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;
  assign cfg_pready = 1'b1;
  assign cfg_idx    = ttdpd_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_idx)
      ttdpd_pkg::REG_PRESCALE: cfg_prdata = {24'd0, prescale_r};
      ttdpd_pkg::REG_TPS:      cfg_prdata = {24'd0, tps_r};
      ttdpd_pkg::REG_TPH:      cfg_prdata = {24'd0, tph_r};
      ttdpd_pkg::REG_GAP_MIN:  cfg_prdata = {16'd0, gap_min_r};
      ttdpd_pkg::REG_GAP_MAX:  cfg_prdata = {16'd0, gap_max_r};
      ttdpd_pkg::REG_PULSES:   cfg_prdata = {24'd0, pulses_r};
      ttdpd_pkg::REG_DC_CLEAR: cfg_prdata = {29'd0, dc_clear_r};
      ttdpd_pkg::REG_PREHEAT:  cfg_prdata = {24'd0, preheat_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= ttdpd_pkg::RstPrescale;
      tps_r      <= ttdpd_pkg::RstTps;
      tph_r      <= ttdpd_pkg::RstTph;
      gap_min_r  <= ttdpd_pkg::RstGapMin;
      gap_max_r  <= ttdpd_pkg::RstGapMax;
      pulses_r   <= ttdpd_pkg::RstPulses;
      dc_clear_r <= ttdpd_pkg::RstDcClear;
      preheat_r  <= ttdpd_pkg::RstPreheat;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ttdpd_pkg::REG_PRESCALE: prescale_r <= cfg_pwdata[7:0];
        ttdpd_pkg::REG_TPS:      tps_r      <= cfg_pwdata[7:0];
        ttdpd_pkg::REG_TPH:      tph_r      <= cfg_pwdata[7:0];
        ttdpd_pkg::REG_GAP_MIN:  gap_min_r  <= cfg_pwdata[15:0];
        ttdpd_pkg::REG_GAP_MAX:  gap_max_r  <= cfg_pwdata[15:0];
        ttdpd_pkg::REG_PULSES:   pulses_r   <= cfg_pwdata[7:0];
        ttdpd_pkg::REG_DC_CLEAR: dc_clear_r <= cfg_pwdata[2:0];
        ttdpd_pkg::REG_PREHEAT:  preheat_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // saturating increments
  assign sub_inc  = (sub_r == 8'hFF)     ? sub_r     : sub_r + 8'd1;
  assign ms_inc   = (ms_r == 8'hFF)      ? ms_r      : ms_r + 8'd1;
  assign half_inc = (half_r == 8'hFF)    ? half_r    : half_r + 8'd1;
  assign vpc_inc  = (vpc_r == 8'hFF)     ? vpc_r     : vpc_r + 8'd1;
  assign gap_inc  = (gap_r == GapMax)    ? gap_r     : gap_r + 1'b1;

  assign fire4     = sub_inc >= prescale_r;
  assign fire_sec  = ms_inc >= tps_r;
  assign fire_half = half_inc >= tph_r;
  assign el_inc    = !fire_sec ? elapsed_r :
                     (elapsed_r == 8'hFF) ? elapsed_r : elapsed_r + 8'd1;
  assign clr_inc   = !fire_sec ? clr_r :
                     (clr_r == 3'h7) ? clr_r : clr_r + 3'd1;
  assign fire_clr  = clr_inc >= dc_clear_r;

  assign gap_ext   = {{(17-ttdpd_pkg::GapCounterBits){1'b0}}, gap_r};
  assign gap_ok    = (gap_ext > {1'b0, gap_min_r}) && (gap_ext < {1'b0, gap_max_r});

  always_comb begin
    sub_nxt     = sub_r;
    ms_nxt      = ms_r;
    half_nxt    = half_r;
    clr_nxt     = clr_r;
    elapsed_nxt = elapsed_r;
    gap_nxt     = gap_r;
    vpc_nxt     = vpc_r;
    dc_nxt      = dc_r;
    res_nxt     = '0;
    if (in_tuser[0] == ttdpd_pkg::ACT_TICK) begin
      sub_nxt = fire4 ? 8'd0 : sub_inc;
      if (fire4) begin
        gap_nxt                  = gap_inc;
        ms_nxt                   = fire_sec ? 8'd0 : ms_inc;
        half_nxt                 = fire_half ? 8'd0 : half_inc;
        elapsed_nxt              = el_inc;
        clr_nxt                  = fire_clr ? 3'd0 : clr_inc;
        res_nxt.four_ms_tick     = 1'b1;
        res_nxt.key_tick         = ms_inc[1];
        res_nxt.second_tick      = fire_sec;
        res_nxt.sleep_tick       = fire_sec && in_tdata[0];
        res_nxt.half_second_tick = fire_half;
        res_nxt.preheat_done     = el_inc >= preheat_r;
        if (fire_clr) begin
          vpc_nxt = 8'd0;
          dc_nxt  = 1'b0;
        end
      end
    end else begin
      if (gap_ok) begin
        if (vpc_r >= pulses_r) dc_nxt = 1'b1;
        vpc_nxt = vpc_inc;
        clr_nxt = 3'd0;
      end
      res_nxt.sleep_clear = 1'b1;
      gap_nxt             = '0;
    end
    res_nxt.dc_present = dc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= '0;
      ms_r        <= '0;
      half_r      <= '0;
      clr_r       <= '0;
      elapsed_r   <= '0;
      gap_r       <= '0;
      vpc_r       <= '0;
      dc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        sub_r     <= sub_nxt;
        ms_r      <= ms_nxt;
        half_r    <= half_nxt;
        clr_r     <= clr_nxt;
        elapsed_r <= elapsed_nxt;
        gap_r     <= gap_nxt;
        vpc_r     <= vpc_nxt;
        dc_r      <= dc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) res_r <= res_nxt;
  end

  // sub-ticks only come from timer words, edges only from edge words
  a_edge_no_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.sleep_clear && (res_r.four_ms_tick || res_r.preheat_done)))
    else $error("edge word carries a tick flag");

  a_slow_needs_fast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.second_tick || res_r.half_second_tick || res_r.key_tick)
    |-> res_r.four_ms_tick)
    else $error("slow tick without 4 ms tick");

  a_sleep_needs_sec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.sleep_tick |-> res_r.second_tick)
    else $error("sleep tick without second tick");

  a_edge_clears_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser[0] == ttdpd_pkg::ACT_EDGE) |=> (gap_r == '0))
    else $error("edge gap not cleared after edge");

  a_dc_mirrors: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (res_r.dc_present == dc_r))
    else $error("dc_present differs from flag");

endmodule
